[hw/rtl/sbsi_pkg.sv]
package sbsi_pkg;

	localparam int COORD_BITS_DEF    = 16;
	localparam int FRACTION_BITS_DEF = 16;

endpackage

[hw/rtl/sbsi_if.sv]
interface sbsi_seg_if #(
	parameter int COORD_BITS = sbsi_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic signed [COORD_BITS-1:0] box_min_x;
	logic signed [COORD_BITS-1:0] box_min_y;
	logic signed [COORD_BITS-1:0] box_max_x;
	logic signed [COORD_BITS-1:0] box_max_y;

	modport source (
		output valid, start_x, start_y, end_x, end_y,
		output box_min_x, box_min_y, box_max_x, box_max_y,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, end_x, end_y,
		input  box_min_x, box_min_y, box_max_x, box_max_y,
		output ready
	);
endinterface

interface sbsi_res_if #(
	parameter int COORD_BITS    = sbsi_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = sbsi_pkg::FRACTION_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [FRACTION_BITS:0]       entry_fraction;
	logic signed [COORD_BITS-1:0] entry_x;
	logic signed [COORD_BITS-1:0] entry_y;

	modport source (output valid, hit, entry_fraction, entry_x, entry_y, input ready);
	modport sink (input valid, hit, entry_fraction, entry_x, entry_y, output ready);
endinterface

[hw/rtl/sbsi_clip.sv]
module sbsi_clip #(
	parameter int COORD_BITS = sbsi_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] sx,
	input  logic signed [COORD_BITS-1:0] sy,
	input  logic signed [COORD_BITS-1:0] ex,
	input  logic signed [COORD_BITS-1:0] ey,
	input  logic signed [COORD_BITS-1:0] mnx,
	input  logic signed [COORD_BITS-1:0] mny,
	input  logic signed [COORD_BITS-1:0] mxx,
	input  logic signed [COORD_BITS-1:0] mxy,
	output logic                         valid_s3,
	output logic                         hit_s3,
	output logic [COORD_BITS:0]          num_s3,
	output logic [COORD_BITS:0]          den_s3,
	output logic signed [COORD_BITS-1:0] sx_s3,
	output logic signed [COORD_BITS-1:0] sy_s3,
	output logic signed [COORD_BITS:0]   dx_s3,
	output logic signed [COORD_BITS:0]   dy_s3
);
	import sbsi_pkg::*;

	localparam int D = COORD_BITS + 1;
	localparam int P = 2 * D;

	logic signed [D-1:0] dx, dy, axn, bxn, ayn, byn, dxa, dya;
	logic signed [D-1:0] lx, hx, ly, hy;
	logic signed [D-1:0] lxn, lxd, hxn, hxd;
	logic                xpar, ypar, x_miss, y_in;

	always_comb begin
		dx  = D'(ex) - D'(sx);
		dy  = D'(ey) - D'(sy);
		axn = D'(mnx) - D'(sx);
		bxn = D'(mxx) - D'(sx);
		ayn = D'(mny) - D'(sy);
		byn = D'(mxy) - D'(sy);
		// Flip to a positive denominator so that the fractions compare by numerator.
		if (dx < 0) begin
			dxa = -dx; axn = -axn; bxn = -bxn;
		end else begin
			dxa = dx;
		end
		if (dy < 0) begin
			dya = -dy; ayn = -ayn; byn = -byn;
		end else begin
			dya = dy;
		end
		lx = (axn > bxn) ? bxn : axn;
		hx = (axn > bxn) ? axn : bxn;
		ly = (ayn > byn) ? byn : ayn;
		hy = (ayn > byn) ? ayn : byn;
		xpar = (dx == '0);
		ypar = (dy == '0);
		y_in = (mny <= sy) && (sy <= mxy);
		if (xpar) begin
			x_miss = !((mnx <= sx) && (sx <= mxx));
			lxn = '0; lxd = D'(1); hxn = D'(1); hxd = D'(1);
		end else begin
			x_miss = (hx < 0) || (lx > dxa);
			lxn = (lx > 0) ? lx : '0;
			lxd = (lx > 0) ? dxa : D'(1);
			hxn = (hx < dxa) ? hx : D'(1);
			hxd = (hx < dxa) ? dxa : D'(1);
		end
	end

	logic                valid_s1, valid_s2;
	logic                xmiss_s1, ypar_s1, yin_s1;
	logic signed [D-1:0] lxn_s1, lxd_s1, hxn_s1, hxd_s1, ly_s1, hy_s1, dya_s1;
	logic signed [COORD_BITS-1:0] sx_s1, sy_s1, sx_s2, sy_s2;
	logic signed [D-1:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic                xmiss_s2, ypar_s2, yin_s2;
	logic signed [D-1:0] lxn_s2, lxd_s2, ly_s2, dya_s2;
	logic signed [P-1:0] p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xmiss_s1 <= x_miss; ypar_s1 <= ypar; yin_s1 <= y_in;
			lxn_s1 <= lxn; lxd_s1 <= lxd; hxn_s1 <= hxn; hxd_s1 <= hxd;
			ly_s1 <= ly; hy_s1 <= hy; dya_s1 <= dya;
			sx_s1 <= sx; sy_s1 <= sy; dx_s1 <= dx; dy_s1 <= dy;

			xmiss_s2 <= xmiss_s1; ypar_s2 <= ypar_s1; yin_s2 <= yin_s1;
			lxn_s2 <= lxn_s1; lxd_s2 <= lxd_s1; ly_s2 <= ly_s1; dya_s2 <= dya_s1;
			sx_s2 <= sx_s1; sy_s2 <= sy_s1; dx_s2 <= dx_s1; dy_s2 <= dy_s1;
			p1_s2 <= P'(hy_s1) * P'(lxd_s1);
			p2_s2 <= P'(lxn_s1) * P'(dya_s1);
			p3_s2 <= P'(ly_s1) * P'(hxd_s1);
			p4_s2 <= P'(hxn_s1) * P'(dya_s1);
			p5_s2 <= P'(ly_s1) * P'(lxd_s1);
		end
	end

	logic                miss2;
	logic signed [D-1:0] lown, lowd;

	// The narrowed interval can only be empty through one of the two early exits.
	always_comb begin
		if (ypar_s2) begin
			miss2 = xmiss_s2 || !yin_s2;
			lown  = lxn_s2;
			lowd  = lxd_s2;
		end else begin
			miss2 = xmiss_s2 || (p1_s2 < p2_s2) || (p3_s2 > p4_s2);
			lown  = (p5_s2 > p2_s2) ? ly_s2 : lxn_s2;
			lowd  = (p5_s2 > p2_s2) ? dya_s2 : lxd_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3 <= !miss2;
			num_s3 <= miss2 ? '0 : lown;
			den_s3 <= miss2 ? D'(1) : lowd;
			sx_s3  <= sx_s2; sy_s3 <= sy_s2;
			dx_s3  <= dx_s2; dy_s3 <= dy_s2;
		end
	end
endmodule

[hw/rtl/sbsi_div.sv]
module sbsi_div #(
	parameter int COORD_BITS    = sbsi_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = sbsi_pkg::FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic                         in_hit,
	input  logic [COORD_BITS:0]          num,
	input  logic [COORD_BITS:0]          den,
	input  logic signed [COORD_BITS-1:0] in_sx,
	input  logic signed [COORD_BITS-1:0] in_sy,
	input  logic signed [COORD_BITS:0]   in_dx,
	input  logic signed [COORD_BITS:0]   in_dy,
	output logic                         out_valid,
	output logic                         out_hit,
	output logic [FRACTION_BITS:0]       quo,
	output logic signed [COORD_BITS-1:0] out_sx,
	output logic signed [COORD_BITS-1:0] out_sy,
	output logic signed [COORD_BITS:0]   out_dx,
	output logic signed [COORD_BITS:0]   out_dy
);
	import sbsi_pkg::*;

	localparam int D = COORD_BITS + 1;
	localparam int F = FRACTION_BITS;

	logic                         v_s   [0:F];
	logic                         hit_s [0:F];
	logic [D:0]                   rem_s [0:F];
	logic [D-1:0]                 den_s [0:F];
	logic [F:0]                   q_s   [0:F];
	logic signed [COORD_BITS-1:0] sx_s  [0:F];
	logic signed [COORD_BITS-1:0] sy_s  [0:F];
	logic signed [D-1:0]          dx_s  [0:F];
	logic signed [D-1:0]          dy_s  [0:F];

	// One quotient bit per stage of a restoring division.
	for (genvar k = 0; k <= F; k++) begin : g_stage
		logic [D:0]   r;
		logic [D-1:0] dd;
		logic         ge;
		logic         vi, hi;
		logic [F:0]   qi;
		logic signed [COORD_BITS-1:0] sxi, syi;
		logic signed [D-1:0] dxi, dyi;

		if (k == 0) begin : g_first
			assign r = {1'b0, num};  assign dd = den;  assign qi = '0;
			assign vi = in_valid;    assign hi = in_hit;
			assign sxi = in_sx; assign syi = in_sy; assign dxi = in_dx; assign dyi = in_dy;
		end else begin : g_next
			assign r  = {rem_s[k-1][D-1:0], 1'b0};
			assign dd = den_s[k-1];  assign qi = q_s[k-1];
			assign vi = v_s[k-1];    assign hi = hit_s[k-1];
			assign sxi = sx_s[k-1]; assign syi = sy_s[k-1];
			assign dxi = dx_s[k-1]; assign dyi = dy_s[k-1];
		end
		assign ge = (r >= {1'b0, dd});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? (r - {1'b0, dd}) : r;
				q_s[k]   <= {qi[F-1:0], ge};
				den_s[k] <= dd;  hit_s[k] <= hi;
				sx_s[k]  <= sxi; sy_s[k] <= syi;
				dx_s[k]  <= dxi; dy_s[k] <= dyi;
			end
		end
	end

	assign out_valid = v_s[F];
	assign out_hit   = hit_s[F];
	assign quo       = q_s[F];
	assign out_sx    = sx_s[F];
	assign out_sy    = sy_s[F];
	assign out_dx    = dx_s[F];
	assign out_dy    = dy_s[F];
endmodule

[hw/rtl/sbsi_point.sv]
module sbsi_point #(
	parameter int COORD_BITS    = sbsi_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = sbsi_pkg::FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic                         in_hit,
	input  logic [FRACTION_BITS:0]       frac,
	input  logic signed [COORD_BITS-1:0] sx,
	input  logic signed [COORD_BITS-1:0] sy,
	input  logic signed [COORD_BITS:0]   dx,
	input  logic signed [COORD_BITS:0]   dy,
	output logic                         valid_s2,
	output logic                         hit_s2,
	output logic [FRACTION_BITS:0]       frac_s2,
	output logic signed [COORD_BITS-1:0] px_s2,
	output logic signed [COORD_BITS-1:0] py_s2
);
	import sbsi_pkg::*;

	localparam int D = COORD_BITS + 1;
	localparam int M = D + FRACTION_BITS + 2;

	logic                         valid_s1, hit_s1;
	logic [FRACTION_BITS:0]       frac_s1;
	logic signed [COORD_BITS-1:0] sx_s1, sy_s1;
	logic signed [M-1:0]          mx_s1, my_s1;
	logic signed [M-1:0]          shx, shy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// The arithmetic shift floors the signed product, as the entry point needs.
	assign shx = mx_s1 >>> FRACTION_BITS;
	assign shy = my_s1 >>> FRACTION_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1  <= in_hit;
			frac_s1 <= frac;
			sx_s1   <= sx;
			sy_s1   <= sy;
			mx_s1   <= M'(dx) * M'(signed'({1'b0, frac}));
			my_s1   <= M'(dy) * M'(signed'({1'b0, frac}));

			hit_s2  <= hit_s1;
			frac_s2 <= hit_s1 ? frac_s1 : '0;
			px_s2   <= hit_s1 ? (sx_s1 + shx[COORD_BITS-1:0]) : '0;
			py_s2   <= hit_s1 ? (sy_s1 + shy[COORD_BITS-1:0]) : '0;
		end
	end
endmodule

[hw/rtl/segment_box_slab_intersection_unit.sv]
// Clips a 2D segment against an axis-aligned box, x slab first and then y slab, and
// returns hit, the entry fraction in Q1.FRACTION_BITS and the entry point; a miss
// gives all zeros. One transaction is taken every cycle unless the output stalls.
// The pipeline has three clip stages with exact cross-multiplied compares, one
// restoring-division stage per quotient bit (FRACTION_BITS + 1 stages, the
// integer bit included), and two stages for the entry-point multiply and the
// output register. The whole pipeline holds while a result waits at the output,
// so ready follows the sink.
module segment_box_slab_intersection_unit #(
	parameter int COORD_BITS    = sbsi_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = sbsi_pkg::FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sbsi_seg_if.sink    req,
	sbsi_res_if.source  rsp
);
	import sbsi_pkg::*;

	logic en;
	logic c_valid, c_hit;
	logic [COORD_BITS:0] c_num, c_den;
	logic signed [COORD_BITS-1:0] c_sx, c_sy, d_sx, d_sy;
	logic signed [COORD_BITS:0]   c_dx, c_dy, d_dx, d_dy;
	logic d_valid, d_hit;
	logic [FRACTION_BITS:0] d_q;

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	sbsi_clip #(.COORD_BITS(COORD_BITS)) u_clip (
		.clk, .arst_n, .en,
		.in_valid(req.valid),
		.sx(req.start_x), .sy(req.start_y), .ex(req.end_x), .ey(req.end_y),
		.mnx(req.box_min_x), .mny(req.box_min_y),
		.mxx(req.box_max_x), .mxy(req.box_max_y),
		.valid_s3(c_valid), .hit_s3(c_hit), .num_s3(c_num), .den_s3(c_den),
		.sx_s3(c_sx), .sy_s3(c_sy), .dx_s3(c_dx), .dy_s3(c_dy)
	);

	sbsi_div #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk, .arst_n, .en,
		.in_valid(c_valid), .in_hit(c_hit), .num(c_num), .den(c_den),
		.in_sx(c_sx), .in_sy(c_sy), .in_dx(c_dx), .in_dy(c_dy),
		.out_valid(d_valid), .out_hit(d_hit), .quo(d_q),
		.out_sx(d_sx), .out_sy(d_sy), .out_dx(d_dx), .out_dy(d_dy)
	);

	sbsi_point #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_point (
		.clk, .arst_n, .en,
		.in_valid(d_valid), .in_hit(d_hit), .frac(d_q),
		.sx(d_sx), .sy(d_sy), .dx(d_dx), .dy(d_dy),
		.valid_s2(rsp.valid), .hit_s2(rsp.hit), .frac_s2(rsp.entry_fraction),
		.px_s2(rsp.entry_x), .py_s2(rsp.entry_y)
	);

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |->
			rsp.entry_fraction == '0 && rsp.entry_x == '0 && rsp.entry_y == '0)
		else $error("miss result carries non-zero fields");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !rsp.entry_fraction[FRACTION_BITS] ||
			rsp.entry_fraction[FRACTION_BITS-1:0] == '0)
		else $error("entry fraction above one");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(d_q) && $stable(d_valid))
		else $error("divider pipeline moved during a stall");
endmodule
